// ----- rtl/mseu_pkg.sv -----
// ----------------------------------------------------------------------------
// mseu_pkg
// Shared types and constants of the integer subset execute unit: command
// codes, the decoded queue entry and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package mseu_pkg;

  // Default data memory depth in words.
  localparam int MEM_WORDS_DEFAULT = 1024;

  // Byte address of data word zero after reset.
  localparam logic [31:0] DATA_BASE_RESET = 32'h1001_0000;

  // Depth of the queue between the decode front and the execute back.
  localparam int QUEUE_DEPTH = 2;

  // Register file geometry.
  localparam int NUM_REGS = 32;
  localparam int REG_W    = 5;
  localparam int WORD_W   = 32;
  localparam int PC_W     = 16;

  // Command codes of the input transaction.
  typedef enum logic [3:0] {
    CMD_LUI     = 4'd0,
    CMD_LW      = 4'd1,
    CMD_SW      = 4'd2,
    CMD_ADD     = 4'd3,
    CMD_SUB     = 4'd4,
    CMD_ADDI    = 4'd5,
    CMD_LI      = 4'd6,
    CMD_SLT     = 4'd7,
    CMD_J       = 4'd8,
    CMD_BEQ     = 4'd9,
    CMD_BNE     = 4'd10,
    CMD_PRELOAD = 4'd11
  } cmd_t;

  // One-hot operation class worked out by the front; wr_reg also folds in
  // the register zero check.
  typedef struct packed {
    logic wr_reg;
    logic is_imm;
    logic is_add;
    logic is_sub;
    logic is_addi;
    logic is_slt;
    logic is_load;
    logic is_store;
    logic is_jump;
    logic is_beq;
    logic is_bne;
    logic is_preload;
  } ctl_t;

  // Decoded instruction as it waits in the queue.
  typedef struct packed {
    ctl_t              ctl;
    logic [REG_W-1:0]  rd;
    logic [REG_W-1:0]  port0_reg;
    logic [REG_W-1:0]  port1_reg;
    logic [WORD_W-1:0] imm;
    logic [WORD_W-1:0] off;
    logic [PC_W-1:0]   target;
  } dec_t;

endpackage

`default_nettype wire

// ----- rtl/mseu_in_if.sv -----
// ----------------------------------------------------------------------------
// mseu_in_if
// Instruction channel: one decoded instruction per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mseu_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic [4:0]         dest_reg;
  logic [4:0]         src_a_reg;
  logic [4:0]         src_b_reg;
  logic signed [31:0] immediate;
  logic [15:0]        target;

  modport source (
    output valid, command, dest_reg, src_a_reg, src_b_reg, immediate, target,
    input  ready
  );

  modport sink (
    input  valid, command, dest_reg, src_a_reg, src_b_reg, immediate, target,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/mseu_out_if.sv -----
// ----------------------------------------------------------------------------
// mseu_out_if
// Result channel: one retired instruction per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mseu_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        next_pc;
  logic               reg_written;
  logic [4:0]         written_reg;
  logic signed [31:0] written_value;
  logic               mem_fault;

  modport source (
    output valid, next_pc, reg_written, written_reg, written_value, mem_fault,
    input  ready
  );

  modport sink (
    input  valid, next_pc, reg_written, written_reg, written_value, mem_fault,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/mseu_ram.sv -----
// ----------------------------------------------------------------------------
// mseu_ram
// Generic single write port, single read port RAM with registered,
// read-first output and a read enable that holds the output.
// ----------------------------------------------------------------------------
`default_nettype none

module mseu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; a read at the write address returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mseu_front.sv -----
// ----------------------------------------------------------------------------
// mseu_front
// Decode front: holds the data base register, accepts instruction
// transactions, classifies them and pushes decoded entries into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mseu_front
  import mseu_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic [31:0]  cfg_wr_data,
  mseu_in_if.sink           instr,
  input  wire logic         mem_busy,
  input  wire logic         q_space,
  output      logic         push,
  output      dec_t         push_data
);

  logic [WORD_W-1:0] data_base;
  cmd_t              cmd;
  ctl_t              ctl;
  logic              rd_nonzero;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_base <= DATA_BASE_RESET;
    end else if (cfg_wr_en) begin
      data_base <= cfg_wr_data;
    end
  end

  // Accept only when the queue has room and the memory clear is done.
  assign instr.ready = q_space && !mem_busy;
  assign push        = instr.valid && instr.ready;

  assign cmd        = cmd_t'(instr.command);
  assign rd_nonzero = (instr.dest_reg != '0);

  // Classify the command into a one-hot operation class.
  always_comb begin
    ctl = '0;
    unique case (cmd)
      CMD_LUI:     begin ctl.is_imm  = 1'b1; ctl.wr_reg = rd_nonzero; end
      CMD_LI:      begin ctl.is_imm  = 1'b1; ctl.wr_reg = rd_nonzero; end
      CMD_ADD:     begin ctl.is_add  = 1'b1; ctl.wr_reg = rd_nonzero; end
      CMD_SUB:     begin ctl.is_sub  = 1'b1; ctl.wr_reg = rd_nonzero; end
      CMD_ADDI:    begin ctl.is_addi = 1'b1; ctl.wr_reg = rd_nonzero; end
      CMD_SLT:     begin ctl.is_slt  = 1'b1; ctl.wr_reg = rd_nonzero; end
      CMD_LW:      begin ctl.is_load = 1'b1; ctl.wr_reg = rd_nonzero; end
      CMD_SW:      ctl.is_store   = 1'b1;
      CMD_J:       ctl.is_jump    = 1'b1;
      CMD_BEQ:     ctl.is_beq     = 1'b1;
      CMD_BNE:     ctl.is_bne     = 1'b1;
      CMD_PRELOAD: ctl.is_preload = 1'b1;
      default:     ctl = '0;
    endcase
  end

  // Build the queue entry: operand port selects, shifted lui value and the
  // offset relative to the data base, so the back needs only one add.
  always_comb begin
    push_data.ctl       = ctl;
    push_data.rd        = instr.dest_reg;
    push_data.port0_reg = (ctl.is_beq || ctl.is_bne) ? instr.dest_reg : instr.src_a_reg;
    push_data.port1_reg = ctl.is_store ? instr.dest_reg : instr.src_b_reg;
    push_data.imm       = (cmd == CMD_LUI) ? {instr.immediate[15:0], 16'h0000}
                                           : instr.immediate;
    push_data.off       = instr.immediate - data_base;
    push_data.target    = instr.target;
  end

endmodule

`default_nettype wire

// ----- rtl/mseu_queue.sv -----
// ----------------------------------------------------------------------------
// mseu_queue
// Short FIFO of decoded entries between the decode front and the execute
// back; a push and a pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mseu_queue
  import mseu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire dec_t push_data,
  output      logic space,
  input  wire logic pop,
  output      dec_t head,
  output      logic head_valid
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  dec_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign space      = (count != CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mseu_back.sv -----
// ----------------------------------------------------------------------------
// mseu_back
// Execute back: reads operands for the queue head, executes in the X stage
// with forwarding, accesses data memory and retires through the output
// register, which writes the register file as it hands off.
// ----------------------------------------------------------------------------
`default_nettype none

module mseu_back
  import mseu_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire dec_t head,
  input  wire logic head_valid,
  output      logic pop,
  output      logic mem_busy,
  mseu_out_if.source result
);

  localparam int IDX_W = $clog2(MEM_WORDS);
  localparam int PL_W  = $clog2(MEM_WORDS + 1);

  // Pipeline advance: the output register is free or being taken.
  logic adv;

  // X stage.
  dec_t              x;
  logic              x_valid;
  logic              x_vld0;
  logic              x_vld1;
  logic [WORD_W-1:0] rf_rd0;
  logic [WORD_W-1:0] rf_rd1;
  logic [WORD_W-1:0] p0;
  logic [WORD_W-1:0] p1;

  // Output stage.
  logic              o_valid;
  logic [PC_W-1:0]   o_next_pc;
  logic              o_wr;
  logic [REG_W-1:0]  o_reg;
  logic [WORD_W-1:0] o_val;
  logic              o_is_load;
  logic              o_fault;
  logic [WORD_W-1:0] o_final;

  // Architectural state.
  logic [PC_W-1:0]   pc;
  logic [PL_W-1:0]   pl_cnt;
  logic [NUM_REGS-1:0] rf_vld;
  logic              last_vld;
  logic [REG_W-1:0]  last_reg;
  logic [WORD_W-1:0] last_val;
  logic              rf_we;

  // Data memory and its clearing pass.
  logic              clearing;
  logic [IDX_W-1:0]  clr_addr;
  logic              dm_we;
  logic [IDX_W-1:0]  dm_waddr;
  logic [WORD_W-1:0] dm_wdata;
  logic [WORD_W-1:0] dm_rdata;

  // X stage results.
  logic [WORD_W-1:0] sum_ab;
  logic [WORD_W-1:0] dif_ab;
  logic [WORD_W-1:0] sum_imm;
  logic [WORD_W-1:0] byte_dist;
  logic              addr_fault;
  logic [IDX_W-1:0]  addr_idx;
  logic              pl_full;
  logic [PC_W-1:0]   x_next_pc;
  logic              x_wr;
  logic [WORD_W-1:0] x_val;
  logic              x_load;
  logic              x_fault;
  logic              x_mem_we;
  logic [IDX_W-1:0]  x_mem_waddr;
  logic [WORD_W-1:0] x_mem_wdata;

  // Operand forwarding: the instruction in the output stage first, then the
  // most recent register write, then the register file read.
  function automatic logic [WORD_W-1:0] pick(
    input logic [REG_W-1:0]  addr,
    input logic [WORD_W-1:0] ram_d,
    input logic              ram_v,
    input logic              o_hit_en,
    input logic [REG_W-1:0]  o_r,
    input logic [WORD_W-1:0] o_d,
    input logic              l_en,
    input logic [REG_W-1:0]  l_r,
    input logic [WORD_W-1:0] l_d
  );
    logic [WORD_W-1:0] v;
    if (o_hit_en && o_r == addr) begin
      v = o_d;
    end else if (l_en && l_r == addr) begin
      v = l_d;
    end else if (ram_v) begin
      v = ram_d;
    end else begin
      v = '0;
    end
    return v;
  endfunction

  assign adv      = !o_valid || result.ready;
  assign pop      = adv && head_valid;
  assign mem_busy = clearing;
  assign o_final  = o_is_load ? dm_rdata : o_val;
  assign rf_we    = adv && o_valid && o_wr;

  // Two copies of the register file give the two operand read ports.
  mseu_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_rf0 (
    .clk   (clk),
    .we    (rf_we),
    .waddr (o_reg),
    .wdata (o_final),
    .re    (adv),
    .raddr (head.port0_reg),
    .rdata (rf_rd0)
  );

  mseu_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_rf1 (
    .clk   (clk),
    .we    (rf_we),
    .waddr (o_reg),
    .wdata (o_final),
    .re    (adv),
    .raddr (head.port1_reg),
    .rdata (rf_rd1)
  );

  assign p0 = pick(x.port0_reg, rf_rd0, x_vld0, o_valid && o_wr, o_reg, o_final,
                   last_vld, last_reg, last_val);
  assign p1 = pick(x.port1_reg, rf_rd1, x_vld1, o_valid && o_wr, o_reg, o_final,
                   last_vld, last_reg, last_val);

  // Arithmetic and address generation.
  assign sum_ab     = p0 + p1;
  assign dif_ab     = p0 - p1;
  assign sum_imm    = p0 + x.imm;
  assign byte_dist  = p0 + x.off;
  assign addr_fault = (byte_dist[31:2] >= 30'(MEM_WORDS));
  assign addr_idx   = byte_dist[IDX_W+1:2];
  assign pl_full    = (pl_cnt >= PL_W'(MEM_WORDS));

  // Execute one instruction.
  always_comb begin
    x_next_pc   = pc + 1'b1;
    x_wr        = 1'b0;
    x_val       = '0;
    x_load      = 1'b0;
    x_fault     = 1'b0;
    x_mem_we    = 1'b0;
    x_mem_waddr = addr_idx;
    x_mem_wdata = p1;
    unique if (x.ctl.is_imm) begin
      x_wr  = x.ctl.wr_reg;
      x_val = x.ctl.wr_reg ? x.imm : '0;
    end else if (x.ctl.is_add) begin
      x_wr  = x.ctl.wr_reg;
      x_val = x.ctl.wr_reg ? sum_ab : '0;
    end else if (x.ctl.is_sub) begin
      x_wr  = x.ctl.wr_reg;
      x_val = x.ctl.wr_reg ? dif_ab : '0;
    end else if (x.ctl.is_addi) begin
      x_wr  = x.ctl.wr_reg;
      x_val = x.ctl.wr_reg ? sum_imm : '0;
    end else if (x.ctl.is_slt) begin
      x_wr  = x.ctl.wr_reg;
      x_val = {31'd0, x.ctl.wr_reg && ($signed(p0) < $signed(p1))};
    end else if (x.ctl.is_load) begin
      if (addr_fault) begin
        x_fault = 1'b1;
      end else begin
        x_wr   = x.ctl.wr_reg;
        x_load = x.ctl.wr_reg;
      end
    end else if (x.ctl.is_store) begin
      if (addr_fault) begin
        x_fault = 1'b1;
      end else begin
        x_mem_we = 1'b1;
        x_val    = p1;
      end
    end else if (x.ctl.is_jump) begin
      x_next_pc = x.target;
    end else if (x.ctl.is_beq) begin
      if (p0 == p1) begin
        x_next_pc = x.target;
      end
    end else if (x.ctl.is_bne) begin
      if (p0 != p1) begin
        x_next_pc = x.target;
      end
    end else if (x.ctl.is_preload) begin
      x_next_pc = pc;
      if (pl_full) begin
        x_fault = 1'b1;
      end else begin
        x_mem_we    = 1'b1;
        x_mem_waddr = pl_cnt[IDX_W-1:0];
        x_mem_wdata = x.imm;
        x_val       = x.imm;
      end
    end else begin
      // Unused command: no operation, pc advances.
      x_wr = 1'b0;
    end
  end

  // Data memory write port: the clearing pass owns it after reset.
  always_comb begin
    if (clearing) begin
      dm_we    = 1'b1;
      dm_waddr = clr_addr;
      dm_wdata = '0;
    end else begin
      dm_we    = adv && x_valid && x_mem_we;
      dm_waddr = x_mem_waddr;
      dm_wdata = x_mem_wdata;
    end
  end

  mseu_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (adv),
    .raddr (addr_idx),
    .rdata (dm_rdata)
  );

  // Pipeline payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      x         <= head;
      x_vld0    <= rf_vld[head.port0_reg];
      x_vld1    <= rf_vld[head.port1_reg];
      o_next_pc <= x_next_pc;
      o_wr      <= x_valid && x_wr;
      o_reg     <= x_wr ? x.rd : '0;
      o_val     <= x_val;
      o_is_load <= x_load;
      o_fault   <= x_fault;
    end
    if (rf_we) begin
      last_reg <= o_reg;
      last_val <= o_final;
    end
  end

  // Control state, architectural counters and the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid  <= 1'b0;
      o_valid  <= 1'b0;
      pc       <= '0;
      pl_cnt   <= '0;
      rf_vld   <= '0;
      last_vld <= 1'b0;
      clearing <= 1'b1;
      clr_addr <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == IDX_W'(MEM_WORDS - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (adv) begin
        x_valid <= head_valid;
        o_valid <= x_valid;
        if (x_valid) begin
          pc <= x_next_pc;
          if (x.ctl.is_preload && !pl_full) begin
            pl_cnt <= pl_cnt + 1'b1;
          end
        end
      end
      if (rf_we) begin
        rf_vld[o_reg] <= 1'b1;
        last_vld      <= 1'b1;
      end
    end
  end

  // Result channel.
  assign result.valid         = o_valid;
  assign result.next_pc       = o_next_pc;
  assign result.reg_written   = o_wr;
  assign result.written_reg   = o_reg;
  assign result.written_value = o_final;
  assign result.mem_fault     = o_fault;

  // Register zero is never written.
  assert property (@(posedge clk) disable iff (rst) rf_we |-> (o_reg != '0))
    else $error("register zero written");

  // The preload count saturates at the memory depth.
  assert property (@(posedge clk) disable iff (rst) pl_cnt <= PL_W'(MEM_WORDS))
    else $error("preload count beyond memory depth");

  // Nothing executes while the memory is being cleared.
  assert property (@(posedge clk) disable iff (rst) clearing |-> (!x_valid && !o_valid))
    else $error("instruction in flight during memory clear");

  // A forwarded load always carries a register write and no fault.
  assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_is_load) |-> (o_wr && !o_fault))
    else $error("load result without register write");

endmodule

`default_nettype wire

// ----- rtl/mips_subset_execute_unit_top.sv -----
// ----------------------------------------------------------------------------
// mips_subset_execute_unit_top
// Execute unit for a small decoded MIPS integer subset with register file,
// word-addressed data memory, program counter and in-order preload.
//
//   Channel   Direction  Handshake            Payload
//   instr     in         valid/ready          command, regs, immediate, target
//   result    out        valid/ready          next_pc, write info, mem_fault
//   cfg       in         cfg_wr_en, no wait   data_base
//
// One instruction per cycle is sustained while the result channel is ready;
// a result passes through the queue, the X stage and the output register
// of the execute back end. After reset a clearing pass zeroes the data
// memory, during which instr.ready stays low; configuration writes are taken.
// A stalled result holds the back end; the two-entry queue lets the front
// keep accepting until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_subset_execute_unit_top
  import mseu_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  mseu_in_if.sink          instr,
  mseu_out_if.source       result
);

  logic mem_busy;
  logic q_space;
  logic push;
  dec_t push_data;
  logic pop;
  dec_t head;
  logic head_valid;

  // Decode front.
  mseu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .instr       (instr),
    .mem_busy    (mem_busy),
    .q_space     (q_space),
    .push        (push),
    .push_data   (push_data)
  );

  // Queue between front and back.
  mseu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .space      (q_space),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // Execute back end.
  mseu_back #(.MEM_WORDS(MEM_WORDS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .mem_busy   (mem_busy),
    .result     (result)
  );

endmodule

`default_nettype wire
